// File: hdl/ssra_pkg.sv
// Shared types, codes and constants for the swap slot reference count allocator.
package ssra_pkg;

	localparam int unsigned SLOTS_DEF = 1024;
	localparam int unsigned EN_W      = 11;
	localparam int unsigned REQ_IDX_W = 10;
	localparam int unsigned REF_W     = 8;

	localparam logic [EN_W-1:0]  EN_RESET = 11'd1024;
	localparam logic [REF_W-1:0] REF_MAX  = 8'hFF;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_REL   = 2'd1;
	localparam logic [1:0] OP_DUP   = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOSPACE  = 3'd1;
	localparam logic [2:0] ST_BADINDEX = 3'd2;
	localparam logic [2:0] ST_RELFREE  = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;
	localparam logic [2:0] ST_DUPFREE  = 3'd5;

	typedef struct packed {
		logic [1:0]           op;
		logic [REQ_IDX_W-1:0] slot_index;
	} req_t;

	typedef struct packed {
		logic [REQ_IDX_W-1:0] slot;
		logic [2:0]           status;
		logic [EN_W-1:0]      free_slots;
	} rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_RMW,
		S_DONE
	} ssra_state_t;

endpackage

// File: hdl/swap_slot_refcount_allocator.sv
// Swap slot allocator top level: config register, sequencer and response register.
//
// Keeps an 8-bit reference count per swap slot in a single-port-write,
// single-port-read memory, plus a free slot count and a next-fit pointer.
// Op allocate scans the count store from the pointer, one entry per cycle,
// wrapping at the end of the enabled range, and grants the first zero count.
// Release decrements and duplicate increments a count; errors come back as
// a status code and leave the state untouched. Requests that end before
// touching the store (bad index, unused op, allocate with no free slot)
// go from idle straight to done; release and duplicate read the count and
// write it back in the read-modify-write state; an allocate scans entries
// until it finds a zero count or has examined every enabled entry. One
// request is in work at a time; a finished response waits in the output
// register while the next request is taken.
// After reset and after every write of slots_enabled a clearing pass zeroes
// all SLOTS entries of the store at one entry per cycle, during which req_stall
// stays high; configuration writes are always taken.
module swap_slot_refcount_allocator #(
	parameter int unsigned SLOTS = ssra_pkg::SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  ssra_pkg::req_t        req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output ssra_pkg::rsp_t        rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [ssra_pkg::EN_W-1:0] cfg_data
);
	import ssra_pkg::*;

	localparam int unsigned CNT_W = $clog2(SLOTS+1);
	localparam int unsigned CLP_W = (CNT_W > EN_W) ? CNT_W : EN_W;

	logic [EN_W-1:0]  slots_en_q;
	logic [CNT_W-1:0] n_en;
	logic             cfg_wr, req_xfer, rsp_take, ctrl_idle, ctrl_pend;
	logic             rsp_valid_q;
	rsp_t             ctrl_rsp, rsp_q;

	// The register is always writable; a write restarts the clearing pass.
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_en_q <= EN_RESET;
		end else if (cfg_wr) begin
			slots_en_q <= cfg_data;
		end
	end

	// Saturate the enabled count at the store depth.
	assign n_en = (CLP_W'(slots_en_q) > CLP_W'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(slots_en_q);

	// Take a new request only when the sequencer sits idle.
	assign req_stall = !ctrl_idle;
	assign req_xfer  = req_valid && !req_stall;

	ssra_ctrl #(.SLOTS(SLOTS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (req_xfer),
		.req      (req),
		.n_en     (n_en),
		.restart  (cfg_wr),
		.rsp_take (rsp_take),
		.idle     (ctrl_idle),
		.rsp_pend (ctrl_pend),
		.rsp      (ctrl_rsp)
	);

	// Move a finished result into the output register once it is free or
	// being drained this cycle; otherwise hold it in the sequencer.
	assign rsp_take = ctrl_pend && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_take) begin
			rsp_q <= ctrl_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: hdl/ssra_ram.sv
// Reference count store: one write port, one read port with registered read data.
module ssra_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/ssra_ctrl.sv
// Sequencer: clearing pass, next-fit scan and read-modify-write of the count store.
module ssra_ctrl #(
	parameter int unsigned SLOTS = ssra_pkg::SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  ssra_pkg::req_t             req,
	input  logic [$clog2(SLOTS+1)-1:0] n_en,
	input  logic                       restart,
	input  logic                       rsp_take,
	output logic                       idle,
	output logic                       rsp_pend,
	output ssra_pkg::rsp_t             rsp
);
	import ssra_pkg::*;

	localparam int unsigned IDX_W = $clog2(SLOTS);
	localparam int unsigned CNT_W = $clog2(SLOTS+1);
	localparam int unsigned CMP_W = (CNT_W > REQ_IDX_W) ? CNT_W : REQ_IDX_W;

	ssra_state_t state_q, state_d;

	logic [IDX_W-1:0]     clr_q, next_q, pos_q, rd_pos_s1, idx_q;
	logic [CNT_W-1:0]     free_q, iss_q, chk_q;
	logic                 rd_vld_s1;
	logic [1:0]           op_q;
	logic [REQ_IDX_W-1:0] echo_q;
	rsp_t                 res_q;

	logic             we, re;
	logic [IDX_W-1:0] waddr, raddr;
	logic [REF_W-1:0] wdata, rdata;

	logic             clr_last, idx_bad, no_space, issue, found, exhausted;
	logic [IDX_W-1:0] start_pos, pos_nxt, hit_nxt;
	logic [CNT_W-1:0] pos_inc, hit_inc;

	logic             rmw_we;
	logic [REF_W-1:0] rmw_wdata;
	logic [2:0]       rmw_status;
	logic [CNT_W-1:0] rmw_free;

	ssra_ram #(.DEPTH(SLOTS), .WIDTH(REF_W)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign clr_last  = (clr_q == IDX_W'(SLOTS - 1));
	assign idx_bad   = (CMP_W'(req.slot_index) >= CMP_W'(n_en));
	assign no_space  = (free_q == '0) || (n_en == '0);
	assign start_pos = (CNT_W'(next_q) < n_en) ? next_q : '0;
	assign pos_inc   = CNT_W'(pos_q) + CNT_W'(1);
	assign pos_nxt   = (pos_inc == n_en) ? '0 : IDX_W'(pos_inc);
	assign hit_inc   = CNT_W'(rd_pos_s1) + CNT_W'(1);
	assign hit_nxt   = (hit_inc == n_en) ? '0 : IDX_W'(hit_inc);
	assign issue     = (iss_q != n_en);
	assign found     = rd_vld_s1 && (rdata == '0);
	assign exhausted = rd_vld_s1 && (rdata != '0) && ((chk_q + CNT_W'(1)) == n_en);

	// release / duplicate update of the fetched count
	always_comb begin
		rmw_we     = 1'b0;
		rmw_wdata  = rdata;
		rmw_status = ST_OK;
		rmw_free   = free_q;
		if (op_q == OP_REL) begin
			if (rdata == '0) begin
				rmw_status = ST_RELFREE;
			end else begin
				rmw_we    = 1'b1;
				rmw_wdata = rdata - REF_W'(1);
				if (rdata == REF_W'(1)) begin
					rmw_free = free_q + CNT_W'(1);
				end
			end
		end else begin
			if (rdata == '0) begin
				rmw_status = ST_DUPFREE;
			end else if (rdata == REF_MAX) begin
				rmw_status = ST_OVERFLOW;
			end else begin
				rmw_we    = 1'b1;
				rmw_wdata = rdata + REF_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = clr_q;
		wdata   = '0;
		re      = 1'b0;
		raddr   = pos_q;
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				if (clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					case (req.op)
						OP_ALLOC: state_d = no_space ? S_DONE : S_SCAN;
						OP_REL, OP_DUP: begin
							if (idx_bad) begin
								state_d = S_DONE;
							end else begin
								re      = 1'b1;
								raddr   = IDX_W'(req.slot_index);
								state_d = S_RMW;
							end
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_SCAN: begin
				re = issue;
				if (found) begin
					we      = 1'b1;
					waddr   = rd_pos_s1;
					wdata   = REF_W'(1);
					state_d = S_DONE;
				end else if (exhausted) begin
					state_d = S_DONE;
				end
			end
			S_RMW: begin
				we      = rmw_we;
				waddr   = idx_q;
				wdata   = rmw_wdata;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (rsp_take) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
		if (restart) begin
			state_d = S_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			free_q    <= '0;
			next_q    <= '0;
			iss_q     <= '0;
			chk_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else if (restart) begin
			clr_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_last ? '0 : clr_q + IDX_W'(1);
					if (clr_last) begin
						free_q <= n_en;
						next_q <= '0;
					end
				end
				S_IDLE: begin
					iss_q     <= '0;
					chk_q     <= '0;
					rd_vld_s1 <= 1'b0;
				end
				S_SCAN: begin
					rd_vld_s1 <= issue;
					if (issue) begin
						iss_q <= iss_q + CNT_W'(1);
					end
					if (rd_vld_s1) begin
						chk_q <= chk_q + CNT_W'(1);
					end
					if (found) begin
						free_q <= free_q - CNT_W'(1);
						next_q <= hit_nxt;
					end
				end
				S_RMW: free_q <= rmw_free;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					op_q             <= req.op;
					idx_q            <= IDX_W'(req.slot_index);
					echo_q           <= req.slot_index;
					pos_q            <= start_pos;
					res_q.free_slots <= EN_W'(free_q);
					if (req.op == OP_ALLOC) begin
						res_q.slot   <= '0;
						res_q.status <= ST_NOSPACE;
					end else if ((req.op == OP_REL || req.op == OP_DUP) && idx_bad) begin
						res_q.slot   <= req.slot_index;
						res_q.status <= ST_BADINDEX;
					end else begin
						res_q.slot   <= req.slot_index;
						res_q.status <= ST_OK;
					end
				end
			end
			S_SCAN: begin
				if (issue) begin
					pos_q     <= pos_nxt;
					rd_pos_s1 <= pos_q;
				end
				if (found) begin
					res_q.slot       <= REQ_IDX_W'(rd_pos_s1);
					res_q.status     <= ST_OK;
					res_q.free_slots <= EN_W'(free_q - CNT_W'(1));
				end
			end
			S_RMW: begin
				res_q.slot       <= echo_q;
				res_q.status     <= rmw_status;
				res_q.free_slots <= EN_W'(rmw_free);
			end
			default: ;
		endcase
	end

	assign idle     = (state_q == S_IDLE);
	assign rsp_pend = (state_q == S_DONE);
	assign rsp      = res_q;

endmodule

// File: hdl/ssra_chk.sv
// Port-level checker for the swap slot allocator, bound to the top level.
module ssra_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_stall,
	input logic                      rsp_valid,
	input logic                      rsp_stall,
	input ssra_pkg::rsp_t            rsp,
	input logic                      cfg_valid,
	input logic                      cfg_ready
);
	import ssra_pkg::*;

	logic [1:0]      pend_q;
	logic            have_q;
	logic [EN_W-1:0] last_free_q;
	logic            req_xfer, rsp_xfer;

	assign req_xfer = req_valid && !req_stall;
	assign rsp_xfer = rsp_valid && !rsp_stall;

	// Track requests whose response has not yet transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(req_xfer) - 2'(rsp_xfer);
		end
	end

	// Remember the free count of the last response since the map was cleared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q      <= 1'b0;
			last_free_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			have_q <= 1'b0;
		end else if (rsp_xfer) begin
			have_q      <= 1'b1;
			last_free_q <= rsp.free_slots;
		end
	end

	a_rsp_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (pend_q != 2'd0 && pend_q <= 2'd2))
		else $error("response without an outstanding request");

	a_nospace_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_NOSPACE) |-> (rsp.slot == '0))
		else $error("out of space response carries a nonzero slot");

	a_fail_keeps_free: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_xfer && have_q && rsp.status != ST_OK) |-> (rsp.free_slots == last_free_q))
		else $error("failed request changed the free slot count");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled response changed");

endmodule

bind swap_slot_refcount_allocator ssra_chk u_ssra_chk (.*);

// File: dv/swap_slot_refcount_allocator_tb.sv
// Self-checking testbench for the swap slot reference count allocator.
`timescale 1ns / 1ps

module swap_slot_refcount_allocator_tb;
	import ssra_pkg::*;

	localparam int unsigned NSLOT = SLOTS_DEF;
	// The run limit covers the slowest correct item (the longest sender gap, a full
	// scan of 1024 entries and the longest receiver stall) over ~1700 items, plus one
	// clearing pass per map setting and the long hold, taken several times over.
	localparam int unsigned LIMIT = 8_000_000;
	localparam int unsigned HOLD_CYCLES = 600;
	localparam int unsigned DRAIN_CYCLES = NSLOT + 64;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_d = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_out;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [EN_W-1:0] cfg_data = '0;

	// Shadow copy of the slot map: per-slot counts, free count, next-fit pointer and
	// the slots_enabled register.
	logic [REF_W-1:0] shadow_refs [NSLOT];
	logic [EN_W-1:0] shadow_free;
	int unsigned shadow_next;
	logic [EN_W-1:0] shadow_en;

	req_t slot_req_q [$];    // requests waiting for the driver
	rsp_t owed_rsp_q [$];    // responses the block owes, oldest first

	int unsigned queued_total = 0;
	int unsigned taken = 0;
	int unsigned settings_run = 0;
	int unsigned errs = 0;
	int unsigned status_seen [8];
	int unsigned cycles = 0;
	int unsigned send_gap;
	int unsigned recv_wait;
	int unsigned hold_left;
	bit hold_done;
	bit hold_armed = 1'b0;
	bit calm = 1'b0;

	swap_slot_refcount_allocator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req_d),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Effective map size: the register saturates at the number of slots.
	function automatic int unsigned enabled_span();
		return (shadow_en > NSLOT) ? NSLOT : int'(shadow_en);
	endfunction

	// Apply a slots_enabled write: clear every count, refill the free count and
	// rewind the pointer.
	function automatic void slot_map_init(logic [EN_W-1:0] en);
		shadow_en = en;
		for (int i = 0; i < NSLOT; i++) shadow_refs[i] = '0;
		shadow_free = EN_W'(enabled_span());
		shadow_next = 0;
	endfunction

	// Advance the shadow map by one request and return the response it owes.
	function automatic rsp_t slot_map_apply(req_t r);
		rsp_t o;
		int unsigned n, pos, k;
		bit found;
		n = enabled_span();
		o.slot = r.slot_index;
		o.status = ST_OK;
		case (r.op)
			OP_ALLOC: begin
				o.slot = '0;
				o.status = ST_NOSPACE;
				if (shadow_free != 0 && n != 0) begin
					// Scan from the pointer, wrapping at the end of the enabled range.
					pos = (shadow_next < n) ? shadow_next : 0;
					found = 1'b0;
					for (k = 0; k < n && !found; k++) begin
						if (shadow_refs[pos] == 0) begin
							shadow_refs[pos] = 8'd1;
							shadow_free = shadow_free - 1'b1;
							shadow_next = (pos + 1 == n) ? 0 : pos + 1;
							o.slot = 10'(pos);
							o.status = ST_OK;
							found = 1'b1;
						end else begin
							pos = (pos + 1 == n) ? 0 : pos + 1;
						end
					end
				end
			end
			OP_REL: begin
				if (r.slot_index >= n) begin
					o.status = ST_BADINDEX;
				end else if (shadow_refs[r.slot_index] == 0) begin
					o.status = ST_RELFREE;
				end else begin
					shadow_refs[r.slot_index] = shadow_refs[r.slot_index] - 1'b1;
					if (shadow_refs[r.slot_index] == 0) shadow_free = shadow_free + 1'b1;
				end
			end
			OP_DUP: begin
				if (r.slot_index >= n) begin
					o.status = ST_BADINDEX;
				end else if (shadow_refs[r.slot_index] == 0) begin
					o.status = ST_DUPFREE;
				end else if (shadow_refs[r.slot_index] == REF_MAX) begin
					o.status = ST_OVERFLOW;
				end else begin
					shadow_refs[r.slot_index] = shadow_refs[r.slot_index] + 1'b1;
				end
			end
			default: begin
				// Unused op: no change, index echoed.
			end
		endcase
		o.free_slots = shadow_free;
		return o;
	endfunction

	// Idle cycles for one transfer on either side; none during calm stretches.
	function automatic int unsigned pace();
		return calm ? 0 : $urandom_range(0, 19);
	endfunction

	function automatic void push_req(logic [1:0] op, logic [REQ_IDX_W-1:0] idx);
		req_t r;
		r.op = op;
		r.slot_index = idx;
		slot_req_q.push_back(r);
		queued_total++;
	endfunction

	// Pick a slot that currently holds a reference, so that most releases and
	// duplicates land on live slots; fall back to a random in-range slot.
	function automatic logic [REQ_IDX_W-1:0] live_slot(int unsigned n);
		int unsigned base, k, p;
		if (n == 0) return 10'($urandom_range(0, NSLOT - 1));
		base = $urandom_range(0, n - 1);
		for (k = 0; k < n; k++) begin
			p = (base + k) % n;
			if (shadow_refs[p] != 0) return 10'(p);
		end
		return 10'(base);
	endfunction

	// Queue a short random sequence: mostly allocate / duplicate / release of live
	// slots, some raw noise, and a few broken sequences (double release).
	task automatic gen_burst(input int unsigned n);
		int unsigned sel, reps, k;
		logic [REQ_IDX_W-1:0] idx;
		sel = $urandom_range(0, 99);
		reps = $urandom_range(1, 4);
		for (k = 0; k < reps; k++) begin
			if (sel < 38) begin
				push_req(OP_ALLOC, 10'($urandom_range(0, NSLOT - 1)));
			end else if (sel < 68) begin
				push_req(OP_REL, live_slot(n));
			end else if (sel < 84) begin
				push_req(OP_DUP, live_slot(n));
			end else if (sel < 94) begin
				push_req(2'($urandom_range(0, 3)), 10'($urandom_range(0, NSLOT - 1)));
			end else begin
				idx = live_slot(n);
				push_req(OP_REL, idx);
				push_req(OP_REL, idx);
				push_req(OP_DUP, idx);
			end
		end
	endtask

	// Block until every queued request has been transferred and answered.
	task automatic wait_drained();
		while (slot_req_q.size() != 0 || req_valid || owed_rsp_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write slots_enabled; only called with the block idle.
	task automatic write_enabled(input logic [EN_W-1:0] en);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= en;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		slot_map_init(en);
		settings_run++;
	endtask

	task automatic run_random_phase(input logic [EN_W-1:0] en, input int unsigned items,
			input bit quiet, input bit hammer);
		int unsigned stop;
		wait_drained();
		calm = quiet;
		write_enabled(en);
		if (hammer) begin
			// Drive one slot to the count ceiling and back past zero: hits count
			// overflow on the way up and release of a free slot at the bottom.
			push_req(OP_ALLOC, '0);
			repeat (256) push_req(OP_DUP, '0);
			repeat (256) push_req(OP_REL, '0);
		end
		stop = queued_total + items;
		while (queued_total < stop) begin
			@(negedge clk);
			if (slot_req_q.size() < 4) gen_burst(enabled_span());
		end
	endtask

	// Driver: offer the head of the request queue, hold it while stalled, and
	// predict the response at the transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_d <= '0;
			send_gap <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				owed_rsp_q.push_back(slot_map_apply(req_d));
				taken++;
			end
			// Advance only when nothing is held on the channel.
			if (!req_valid || !req_stall) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					req_valid <= 1'b0;
				end else if (slot_req_q.size() != 0) begin
					req_d <= slot_req_q.pop_front();
					req_valid <= 1'b1;
					send_gap <= pace();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each response transfer against the oldest owed response,
	// then decide how long to stall the next one.
	always @(posedge clk or negedge arst_n) begin : rx_side
		rsp_t e;
		int unsigned w;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			recv_wait <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (owed_rsp_q.size() == 0) begin
					$error("response with nothing owed: slot %0d status %0d free_slots %0d",
						rsp_out.slot, rsp_out.status, rsp_out.free_slots);
					errs++;
				end else begin
					e = owed_rsp_q.pop_front();
					status_seen[e.status]++;
					if (rsp_out.slot !== e.slot) begin
						$error("slot: expected %0d, actual %0d", e.slot, rsp_out.slot);
						errs++;
					end
					if (rsp_out.status !== e.status) begin
						$error("status: expected %0d, actual %0d", e.status, rsp_out.status);
						errs++;
					end
					if (rsp_out.free_slots !== e.free_slots) begin
						$error("free_slots: expected %0d, actual %0d",
							e.free_slots, rsp_out.free_slots);
						errs++;
					end
				end
			end
			if (hold_left != 0) begin
				// Long hold-off: the block fills and must stall its request side.
				hold_left <= hold_left - 1;
				rsp_stall <= (hold_left > 1);
			end else if (hold_armed && !hold_done && rsp_valid && !rsp_stall) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				rsp_stall <= 1'b1;
			end else if (rsp_valid && !rsp_stall) begin
				w = pace();
				recv_wait <= w;
				rsp_stall <= (w != 0);
			end else if (recv_wait != 0) begin
				recv_wait <= recv_wait - 1;
				rsp_stall <= (recv_wait > 1);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$error("run exceeded %0d cycles", LIMIT);
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		slot_map_init(EN_RESET);

		// Directed, reset map of 1024 slots: unused op with an all-ones index,
		// release and duplicate of free slots, next-fit past a freed slot.
		push_req(2'd3, 10'd1023);
		push_req(OP_REL, 10'd0);
		push_req(OP_DUP, 10'd0);
		push_req(OP_ALLOC, 10'd1023);
		push_req(OP_ALLOC, 10'd0);
		push_req(OP_DUP, 10'd1);
		push_req(OP_REL, 10'd1);
		push_req(OP_REL, 10'd1);
		push_req(OP_REL, 10'd1);
		push_req(OP_ALLOC, 10'd0);
		push_req(OP_DUP, 10'd1023);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Two-slot map: fill, run out of space, bad indexes, pointer wrap.
		wait_drained();
		write_enabled(11'd2);
		push_req(OP_ALLOC, 10'd0);
		push_req(OP_ALLOC, 10'd0);
		push_req(OP_ALLOC, 10'd0);
		push_req(OP_REL, 10'd1023);
		push_req(OP_DUP, 10'd2);
		push_req(OP_REL, 10'd0);
		push_req(OP_ALLOC, 10'd0);
		push_req(OP_REL, 10'd1);
		push_req(OP_ALLOC, 10'd0);

		// Zero enabled slots: no space and every index bad.
		wait_drained();
		write_enabled(11'd0);
		push_req(OP_ALLOC, 10'd0);
		push_req(OP_REL, 10'd0);
		push_req(OP_DUP, 10'd0);
		push_req(2'd3, 10'd0);

		// Random phases over several map sizes, the oversize setting among them.
		wait_drained();
		hold_armed = 1'b1;
		run_random_phase(11'd1024, 300, 1'b0, 1'b1);
		run_random_phase(11'd1, 60, 1'b1, 1'b0);
		run_random_phase(11'd2047, 200, 1'b0, 1'b0);
		run_random_phase(11'd13, 150, 1'b1, 1'b0);
		run_random_phase(11'd3, 80, 1'b0, 1'b0);
		run_random_phase(11'd700, 200, 1'b0, 1'b0);
		run_random_phase(11'd1023, 120, 1'b1, 1'b0);

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (owed_rsp_q.size() != 0) begin
			$error("%0d responses never arrived", owed_rsp_q.size());
			errs++;
		end

		$display("Covered %0d requests across %0d slots_enabled writes (0, 1, 1024, oversize).",
			taken, settings_run);
		$display("Statuses: ok %0d, no space %0d, bad index %0d, release free %0d, %s %0d, %s %0d",
			status_seen[ST_OK], status_seen[ST_NOSPACE], status_seen[ST_BADINDEX],
			status_seen[ST_RELFREE], "overflow", status_seen[ST_OVERFLOW],
			"dup free", status_seen[ST_DUPFREE]);
		if (errs == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// File: files.f
hdl/ssra_pkg.sv
hdl/ssra_ram.sv
hdl/ssra_ctrl.sv
hdl/swap_slot_refcount_allocator.sv
hdl/ssra_chk.sv
dv/swap_slot_refcount_allocator_tb.sv
